[design/i2a_pkg.sv]
// Shared widths, command codes and the digit-to-ASCII function for the formatter.
package i2a_pkg;

    localparam int VAL_W      = 32;
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int DIG_W      = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * DIG_W;
    localparam int CNT_W      = $clog2(BCD_DIGITS + 1);
    localparam int STEP_W     = $clog2(VAL_W + 1);
    localparam int BYTE_W     = 8;

    localparam logic [CMD_W-1:0] CMD_UDEC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SDEC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HEX  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h37;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIG_W){1'b0}}, d};
        return (d <= 4'd9) ? (CH_ZERO + ext) : (CH_ALPHA + ext);
    endfunction

endpackage

[design/i2a_dabble.sv]
// Shift-and-add-3 binary to BCD converter, one bit per cycle.
module i2a_dabble (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [i2a_pkg::VAL_W-1:0]  bin,
    output logic                       done,
    output logic [i2a_pkg::BCD_W-1:0]  bcd
);
    import i2a_pkg::*;

    logic [VAL_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BCD_W-1:0]  adj;

    always_comb
    begin
        adj = bcd_reg;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (adj[i*DIG_W +: DIG_W] >= 4'd5)
            begin
                adj[i*DIG_W +: DIG_W] = adj[i*DIG_W +: DIG_W] + 4'd3;
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = bin;
            bcd_next  = '0;
            step_next = STEP_W'(VAL_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adj[BCD_W-2:0], bin_reg[VAL_W-1]};
            bin_next  = {bin_reg[VAL_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("conversion done without a running conversion");

    a_busy_steps: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg != '0)
        else $error("conversion busy with no steps left");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("conversion done held longer than one cycle");

endmodule

[design/integer_to_ascii_formatter.sv]
// Top level: sequencer, digit buffer and output register of the ASCII formatter.
//
// channel | signals                              | direction
// in      | in_valid in_ready command value      | request in
//         | final_byte                           |
// out     | out_valid out_ready character last   | request out
//         | dump_end                             |
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Decimal requests pass through the shared shift-and-add-3 converter, then drop
// each leading zero (up to 9), then push the digits, behind a minus sign when one
// is needed. Prefixed hex also drops leading zeros, byte hex keeps both digits.
// A stalled out_ready holds the sequencer; reset empties the output register.
module integer_to_ascii_formatter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [i2a_pkg::CMD_W-1:0]    command,
    input  logic [i2a_pkg::VAL_W-1:0]    value,
    input  logic                         final_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [i2a_pkg::CHAR_W-1:0]   character,
    output logic                         last,
    output logic                         dump_end
);
    import i2a_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SKIP = 3'd2;
    localparam logic [2:0] S_PRE  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic              dump_reg, dump_next;
    logic [1:0]        pre_reg, pre_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BCD_W-1:0]  dig_reg, dig_next;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              dump_end_reg;

    logic              accept;
    logic              can_push;
    logic              push;
    logic [CHAR_W-1:0] push_char;
    logic              push_last;
    logic              push_dump;
    logic              dab_start;
    logic [VAL_W-1:0]  dab_bin;
    logic              dab_done;
    logic [BCD_W-1:0]  dab_bcd;
    logic [DIG_W-1:0]  top_dig;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign can_push = !out_valid_reg || out_ready;
    assign top_dig  = dig_reg[BCD_W-1 -: DIG_W];

    assign dab_start = accept && (command == CMD_UDEC || command == CMD_SDEC);
    assign dab_bin   = (command == CMD_SDEC && value[VAL_W-1]) ? (VAL_W'(0) - value) : value;

    i2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .bin   (dab_bin),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        dump_next  = dump_reg;
        pre_next   = pre_reg;
        cnt_next   = cnt_reg;
        dig_next   = dig_reg;
        push       = 1'b0;
        push_char  = digit_char(top_dig);
        push_last  = 1'b0;
        push_dump  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = command;
                    dump_next = (command == CMD_BYTE) && final_byte;
                    unique case (command)
                        CMD_UDEC:
                        begin
                            pre_next   = 2'd0;
                            state_next = S_CONV;
                        end
                        CMD_SDEC:
                        begin
                            pre_next   = value[VAL_W-1] ? 2'd1 : 2'd0;
                            state_next = S_CONV;
                        end
                        CMD_HEX:
                        begin
                            pre_next   = 2'd2;
                            dig_next   = {value, {(BCD_W-VAL_W){1'b0}}};
                            cnt_next   = CNT_W'(VAL_W / DIG_W);
                            state_next = S_SKIP;
                        end
                        default:
                        begin
                            pre_next   = 2'd0;
                            dig_next   = {value[BYTE_W-1:0], {(BCD_W-BYTE_W){1'b0}}};
                            cnt_next   = CNT_W'(BYTE_W / DIG_W);
                            state_next = S_SKIP;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                if (dab_done)
                begin
                    dig_next   = dab_bcd;
                    cnt_next   = CNT_W'(BCD_DIGITS);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (top_dig == '0 && cnt_reg > CNT_W'(1) && cmd_reg != CMD_BYTE)
                begin
                    dig_next = {dig_reg[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = (pre_reg != 2'd0) ? S_PRE : S_EMIT;
                end
            end
            S_PRE:
            begin
                if (cmd_reg == CMD_HEX)
                begin
                    push_char = (pre_reg == 2'd2) ? CH_ZERO : CH_X;
                end
                else
                begin
                    push_char = CH_MINUS;
                end
                if (can_push)
                begin
                    push     = 1'b1;
                    pre_next = pre_reg - 1'b1;
                    if (pre_reg == 2'd1)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                push_last = (cnt_reg == CNT_W'(1));
                push_dump = push_last && dump_reg;
                if (can_push)
                begin
                    push     = 1'b1;
                    dig_next = {dig_reg[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    cnt_next = cnt_reg - 1'b1;
                    if (push_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        dump_reg <= dump_next;
        pre_reg  <= pre_next;
        cnt_reg  <= cnt_next;
        dig_reg  <= dig_next;
        if (push)
        begin
            char_reg     <= push_char;
            last_reg     <= push_last;
            dump_end_reg <= push_dump;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign dump_end  = dump_end_reg;

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        dab_done |-> state_reg == S_CONV)
        else $error("converter finished outside the conversion state");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> cnt_reg != '0)
        else $error("emitting with no digits left");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_last |=> state_reg == S_IDLE)
        else $error("last character pushed without returning to idle");

    a_no_push_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> can_push && (state_reg == S_PRE || state_reg == S_EMIT))
        else $error("character pushed over a held output");

endmodule
